### rtl/core/rsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsa_pkg;

    localparam int SLOT_COUNT = 256;
    localparam int PAGE_BITS  = 16;

    // Slot numbers travel in 8 bits, so at most 256 slots are ever used.
    localparam int LIVE_SLOTS = (SLOT_COUNT < 256) ? SLOT_COUNT : 256;
    localparam int IDX_W      = (LIVE_SLOTS > 1) ? $clog2(LIVE_SLOTS) : 1;

    localparam int SLOT_W = 8;
    localparam int ADDR_W = 25;
    localparam int CNT_W  = SLOT_W + 1;

    localparam logic [ADDR_W:0]   PAGE_MASK = (ADDR_W + 1)'((1 << PAGE_BITS) - 1);
    localparam logic [ADDR_W+1:0] ADDR_MAX  = (ADDR_W + 2)'((1 << ADDR_W) - 1);

    typedef enum logic [2:0] {
        KIND_LOOKUP   = 3'd0,
        KIND_REGISTER = 3'd1,
        KIND_DELETE   = 3'd2,
        KIND_SELECT   = 3'd3,
        KIND_CLEAR    = 3'd4
    } kind_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [SLOT_W-1:0] position;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] rom_size;
    } cmd_t;

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] found_slot;
        logic [ADDR_W-1:0] entry_address;
        logic [ADDR_W-1:0] entry_size;
        logic [ADDR_W-1:0] free_address;
        logic [ADDR_W-1:0] free_bytes;
        logic [SLOT_W-1:0] current_slot;
        logic [ADDR_W-1:0] current_address;
    } result_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] length;
    } entry_t;

endpackage

`default_nettype wire

### rtl/core/rom_slot_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// ROM slot allocator: a table of ROM slots (valid mark, start address, size)
// in a flash partition, with lookup, register, delete, select and clear.
//
// Command channel: a transaction is taken at a rising edge with start high
// and busy low; cmd carries kind, position, slot and rom_size. Result
// channel: done is high for exactly one cycle while result holds the
// outcome; the receiver cannot hold it off, so it must take it then.
// Configuration: cfg_valid/cfg_ready write partition_size; cfg_ready is
// always high and writes belong to idle periods.
//
// Every command walks the entry memory once, one slot a cycle, to find the
// n-th valid slot, the first free slot and the highest end address. A
// new command is taken only after the last one ends; done rises in the
// cycle busy falls. The walk over the single read port of the entry
// memory sets how long a command lasts.
//
// Reset clears all valid marks, the current selection and restores
// partition_size to 1 MiB. Entry contents are not cleared: they are only
// used for valid slots.
module rom_slot_allocator
    import rsa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire cmd_t              cmd,
    output logic                   done,
    output result_t                result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [ADDR_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_FIN  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [ADDR_W:0]     len_reg, len_next;
    logic [IDX_W:0]      rd_cnt_reg, rd_cnt_next;
    logic                p_vld_reg, p_vld_next;
    logic [IDX_W-1:0]    p_idx_reg, p_idx_next;
    logic                p_ev_reg, p_ev_next;
    logic [ADDR_W:0]     max_reg, max_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                hit_reg, hit_next;
    logic [IDX_W-1:0]    f_slot_reg, f_slot_next;
    logic [ADDR_W-1:0]   f_addr_reg, f_addr_next;
    logic [ADDR_W-1:0]   f_size_reg, f_size_next;
    logic                ok_reg, ok_next;
    logic [ADDR_W:0]     free_reg, free_next;
    logic [LIVE_SLOTS-1:0] valid_reg, valid_next;
    logic [SLOT_W-1:0]   sel_slot_reg, sel_slot_next;
    logic [ADDR_W-1:0]   sel_addr_reg, sel_addr_next;
    result_t             res_reg, res_next;
    logic                done_reg, done_next;
    logic [ADDR_W-1:0]   part_reg, part_next;

    // Entry memory: one write port, one registered read port.
    entry_t              entry_mem [LIVE_SLOTS];
    entry_t              rdata_reg;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    entry_t              mem_wdata;
    logic                mem_re;
    logic [IDX_W-1:0]    mem_raddr;

    logic                slot_live;
    logic [ADDR_W:0]     rd_end;
    logic [ADDR_W+1:0]   reg_sum;
    logic                reg_ok;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= entry_mem[mem_raddr];
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = res_reg;
    assign cfg_ready = 1'b1;

    // Slot number within the used range and currently valid.
    assign slot_live = ({1'b0, cmd.slot} < CNT_W'(LIVE_SLOTS))
                       && valid_reg[cmd.slot[IDX_W-1:0]];

    assign rd_end  = {1'b0, rdata_reg.start} + {1'b0, rdata_reg.length};
    assign reg_sum = {1'b0, max_reg} + {1'b0, len_reg};
    assign reg_ok  = hit_reg && (reg_sum <= ADDR_MAX);

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        len_next      = len_reg;
        rd_cnt_next   = rd_cnt_reg;
        p_vld_next    = 1'b0;
        p_idx_next    = p_idx_reg;
        p_ev_next     = p_ev_reg;
        max_next      = max_reg;
        cnt_next      = cnt_reg;
        hit_next      = hit_reg;
        f_slot_next   = f_slot_reg;
        f_addr_next   = f_addr_reg;
        f_size_next   = f_size_reg;
        ok_next       = ok_reg;
        free_next     = free_reg;
        valid_next    = valid_reg;
        sel_slot_next = sel_slot_reg;
        sel_addr_next = sel_addr_reg;
        res_next      = res_reg;
        done_next     = 1'b0;
        part_next     = part_reg;
        mem_we        = 1'b0;
        mem_waddr     = f_slot_reg;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = rd_cnt_reg[IDX_W-1:0];

        if (cfg_valid)
        begin
            part_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // Latch the command and apply the changes that need no walk.
                    cmd_next    = cmd;
                    len_next    = ({1'b0, cmd.rom_size} + PAGE_MASK) & ~PAGE_MASK;
                    rd_cnt_next = '0;
                    max_next    = '0;
                    cnt_next    = '0;
                    hit_next    = 1'b0;
                    f_slot_next = '0;
                    f_addr_next = '0;
                    f_size_next = '0;
                    ok_next     = 1'b0;
                    case (cmd.kind)
                        KIND_DELETE:
                        begin
                            if (slot_live)
                            begin
                                valid_next[cmd.slot[IDX_W-1:0]] = 1'b0;
                                ok_next = 1'b1;
                            end
                        end
                        KIND_SELECT:
                        begin
                            ok_next = slot_live;
                        end
                        KIND_CLEAR:
                        begin
                            valid_next    = '0;
                            sel_slot_next = '0;
                            sel_addr_next = '0;
                            ok_next       = 1'b1;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Issue stage: read one slot a cycle.
                if (rd_cnt_reg < (IDX_W + 1)'(LIVE_SLOTS))
                begin
                    mem_re      = 1'b1;
                    p_vld_next  = 1'b1;
                    p_idx_next  = rd_cnt_reg[IDX_W-1:0];
                    p_ev_next   = valid_reg[rd_cnt_reg[IDX_W-1:0]];
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_FIN;
                end

                // Data stage: fold the entry read in the previous cycle.
                if (p_vld_reg)
                begin
                    if (p_ev_reg && (rd_end > max_reg))
                    begin
                        max_next = rd_end;
                    end
                    case (cmd_reg.kind)
                        KIND_LOOKUP:
                        begin
                            if (p_ev_reg && !hit_reg)
                            begin
                                if (cnt_reg == {1'b0, cmd_reg.position})
                                begin
                                    hit_next    = 1'b1;
                                    f_slot_next = p_idx_reg;
                                    f_addr_next = rdata_reg.start;
                                    f_size_next = rdata_reg.length;
                                end
                                else
                                begin
                                    cnt_next = cnt_reg + 1'b1;
                                end
                            end
                        end
                        KIND_REGISTER:
                        begin
                            if (!p_ev_reg && !hit_reg)
                            begin
                                hit_next    = 1'b1;
                                f_slot_next = p_idx_reg;
                            end
                        end
                        KIND_SELECT:
                        begin
                            if (SLOT_W'(p_idx_reg) == cmd_reg.slot)
                            begin
                                f_addr_next = rdata_reg.start;
                            end
                        end
                        default:
                        begin
                            hit_next = hit_reg;
                        end
                    endcase
                end
            end

            ST_FIN:
            begin
                free_next = max_reg;
                case (cmd_reg.kind)
                    KIND_LOOKUP:
                    begin
                        ok_next = hit_reg;
                    end
                    KIND_REGISTER:
                    begin
                        ok_next = reg_ok;
                        if (reg_ok)
                        begin
                            mem_we                 = 1'b1;
                            mem_wdata.start        = max_reg[ADDR_W-1:0];
                            mem_wdata.length       = len_reg[ADDR_W-1:0];
                            valid_next[f_slot_reg] = 1'b1;
                            f_addr_next            = max_reg[ADDR_W-1:0];
                            f_size_next            = len_reg[ADDR_W-1:0];
                            free_next              = reg_sum[ADDR_W:0];
                        end
                    end
                    KIND_SELECT:
                    begin
                        if (ok_reg)
                        begin
                            sel_slot_next = cmd_reg.slot;
                            sel_addr_next = f_addr_reg;
                        end
                    end
                    default:
                    begin
                        ok_next = ok_reg;
                    end
                endcase
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                res_next.ok            = ok_reg;
                res_next.found_slot    = '0;
                res_next.entry_address = '0;
                res_next.entry_size    = '0;
                if (ok_reg && ((cmd_reg.kind == KIND_LOOKUP)
                               || (cmd_reg.kind == KIND_REGISTER)))
                begin
                    res_next.found_slot    = SLOT_W'(f_slot_reg);
                    res_next.entry_address = f_addr_reg;
                    res_next.entry_size    = f_size_reg;
                end
                res_next.free_address = free_reg[ADDR_W-1:0];
                if ({1'b0, part_reg} > free_reg)
                begin
                    res_next.free_bytes = part_reg - free_reg[ADDR_W-1:0];
                end
                else
                begin
                    res_next.free_bytes = '0;
                end
                res_next.current_slot    = sel_slot_reg;
                res_next.current_address = sel_addr_reg;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_cnt_reg   <= '0;
            p_vld_reg    <= 1'b0;
            valid_reg    <= '0;
            sel_slot_reg <= '0;
            sel_addr_reg <= '0;
            done_reg     <= 1'b0;
            part_reg     <= ADDR_W'(1048576);
        end
        else
        begin
            state_reg    <= state_next;
            rd_cnt_reg   <= rd_cnt_next;
            p_vld_reg    <= p_vld_next;
            valid_reg    <= valid_next;
            sel_slot_reg <= sel_slot_next;
            sel_addr_reg <= sel_addr_next;
            done_reg     <= done_next;
            part_reg     <= part_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        len_reg    <= len_next;
        p_idx_reg  <= p_idx_next;
        p_ev_reg   <= p_ev_next;
        max_reg    <= max_next;
        cnt_reg    <= cnt_next;
        hit_reg    <= hit_next;
        f_slot_reg <= f_slot_next;
        f_addr_reg <= f_addr_next;
        f_size_reg <= f_size_next;
        ok_reg     <= ok_next;
        free_reg   <= free_next;
        res_reg    <= res_next;
    end

endmodule

`default_nettype wire

### verif/rom_slot_allocator_tb.sv
`timescale 1ns / 1ps

module rom_slot_allocator_tb;
    import rsa_pkg::*;

    // Kinds past CLEAR have no meaning and must be refused without a change.
    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

    localparam longint ADDR_LIMIT   = (longint'(1) << ADDR_W) - 1;
    localparam longint PAGE_SPAN    = longint'(1) << PAGE_BITS;
    localparam int     DRAIN_CYCLES = LIVE_SLOTS + 8;

    // One row of the directed table: the command, and the outcome typed in by
    // hand where it is obvious (otherwise the predictor supplies it).
    typedef struct {
        cmd_t    cmd;
        bit      typed;
        result_t want;
    } step_row_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    cmd_t              command   = '0;
    logic              cfg_valid = 1'b0;
    logic [ADDR_W-1:0] cfg_data  = '0;
    logic              busy;
    logic              done;
    result_t           outcome;
    logic              cfg_ready;

    // Predictor copy of the slot table, the selection and the partition size.
    bit                slot_used [LIVE_SLOTS];
    logic [ADDR_W-1:0] slot_base [LIVE_SLOTS];
    logic [ADDR_W-1:0] slot_len  [LIVE_SLOTS];
    logic [SLOT_W-1:0] sel_slot   = '0;
    logic [ADDR_W-1:0] sel_addr   = '0;
    logic [ADDR_W-1:0] part_bytes = ADDR_W'(1048576);

    result_t   pending_outcomes[$];
    step_row_t rows[$];
    int        sender_idle_pct  = 0;
    int        mismatch_count   = 0;
    int        outcomes_checked = 0;
    int        kind_count[8];

    rom_slot_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (command),
        .done      (done),
        .result    (outcome),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard stop: far beyond the slowest correct run (about 500 commands plus
    // the longest sender gaps).
    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic longint page_up(input longint v);
        return (v + PAGE_SPAN - 1) & ~(PAGE_SPAN - 1);
    endfunction

    // Free address: the highest page-rounded end over all valid slots.
    function automatic longint top_of_used();
        longint top;
        longint e;
        top = 0;
        for (int i = 0; i < LIVE_SLOTS; i++)
            if (slot_used[i])
            begin
                e = page_up(longint'(slot_base[i]) + longint'(slot_len[i]));
                if (e > top)
                    top = e;
            end
        return top;
    endfunction

    // Advance the predictor by one command and return the outcome it implies.
    function automatic result_t predict_outcome(input cmd_t c);
        result_t r;
        longint  base;
        longint  len;
        longint  fa;
        int      seen;
        int      idx;
        r = '0;
        case (c.kind)
            KIND_LOOKUP:
            begin
                seen = 0;
                for (int i = 0; i < LIVE_SLOTS; i++)
                    if (slot_used[i] && !r.ok)
                    begin
                        if (seen == int'(c.position))
                        begin
                            r.ok            = 1'b1;
                            r.found_slot    = SLOT_W'(i);
                            r.entry_address = slot_base[i];
                            r.entry_size    = slot_len[i];
                        end
                        seen++;
                    end
            end
            KIND_REGISTER:
            begin
                base = top_of_used();
                len  = page_up(longint'(c.rom_size));
                idx  = LIVE_SLOTS;
                for (int i = LIVE_SLOTS - 1; i >= 0; i--)
                    if (!slot_used[i])
                        idx = i;
                // Refuse when the table is full or the end passes the address range.
                if (idx < LIVE_SLOTS && base + len <= ADDR_LIMIT)
                begin
                    slot_used[idx]  = 1'b1;
                    slot_base[idx]  = ADDR_W'(base);
                    slot_len[idx]   = ADDR_W'(len);
                    r.ok            = 1'b1;
                    r.found_slot    = SLOT_W'(idx);
                    r.entry_address = ADDR_W'(base);
                    r.entry_size    = ADDR_W'(len);
                end
            end
            KIND_DELETE:
                // The current selection survives the delete of its slot.
                if (int'(c.slot) < LIVE_SLOTS && slot_used[c.slot])
                begin
                    slot_used[c.slot] = 1'b0;
                    r.ok              = 1'b1;
                end
            KIND_SELECT:
                if (int'(c.slot) < LIVE_SLOTS && slot_used[c.slot])
                begin
                    sel_slot = c.slot;
                    sel_addr = slot_base[c.slot];
                    r.ok     = 1'b1;
                end
            KIND_CLEAR:
            begin
                for (int i = 0; i < LIVE_SLOTS; i++)
                    slot_used[i] = 1'b0;
                sel_slot = '0;
                sel_addr = '0;
                r.ok     = 1'b1;
            end
            default: ;
        endcase
        fa                = top_of_used();
        r.free_address    = ADDR_W'(fa);
        r.free_bytes      = (longint'(part_bytes) > fa) ? ADDR_W'(longint'(part_bytes) - fa) : '0;
        r.current_slot    = sel_slot;
        r.current_address = sel_addr;
        return r;
    endfunction

    function automatic cmd_t make_command(input logic [2:0] kind, input logic [SLOT_W-1:0] pos,
                                          input logic [SLOT_W-1:0] slot,
                                          input logic [ADDR_W-1:0] size);
        cmd_t c;
        c.kind     = kind;
        c.position = pos;
        c.slot     = slot;
        c.rom_size = size;
        return c;
    endfunction

    function automatic result_t typed_outcome(input logic ok, input logic [SLOT_W-1:0] fslot,
                                              input logic [ADDR_W-1:0] faddr,
                                              input logic [ADDR_W-1:0] fsize,
                                              input logic [ADDR_W-1:0] fa,
                                              input logic [ADDR_W-1:0] fb,
                                              input logic [SLOT_W-1:0] cs,
                                              input logic [ADDR_W-1:0] ca);
        result_t r;
        r.ok              = ok;
        r.found_slot      = fslot;
        r.entry_address   = faddr;
        r.entry_size      = fsize;
        r.free_address    = fa;
        r.free_bytes      = fb;
        r.current_slot    = cs;
        r.current_address = ca;
        return r;
    endfunction

    function automatic void add_row(input cmd_t c, input bit typed, input result_t want);
        step_row_t row;
        row.cmd   = c;
        row.typed = typed;
        row.want  = want;
        rows.push_back(row);
    endfunction

    // Mostly small positions, slots and sizes so that commands hit live
    // slots; the rest spans every bit of each field.
    function automatic cmd_t random_command();
        cmd_t c;
        int   pick;
        int   size_pick;
        pick       = $urandom_range(0, 99);
        size_pick  = $urandom_range(0, 9);
        c.position = ($urandom_range(0, 9) < 6) ? SLOT_W'($urandom_range(0, 15))
                                                : SLOT_W'($urandom);
        c.slot     = ($urandom_range(0, 9) < 6) ? SLOT_W'($urandom_range(0, 15))
                                                : SLOT_W'($urandom);
        if (size_pick < 7)
            c.rom_size = ADDR_W'($urandom_range(0, 20'hFFFFF));
        else if (size_pick < 9)
            c.rom_size = ADDR_W'($urandom_range(0, 4095));
        else
            c.rom_size = ADDR_W'($urandom);
        if (pick < 25)
            c.kind = KIND_LOOKUP;
        else if (pick < 55)
            c.kind = KIND_REGISTER;
        else if (pick < 70)
            c.kind = KIND_DELETE;
        else if (pick < 90)
            c.kind = KIND_SELECT;
        else if (pick < 93)
            c.kind = KIND_CLEAR;
        else
            c.kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
        return c;
    endfunction

    task automatic note_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic compare_outcome(input result_t got, input result_t want);
        if (got.ok !== want.ok)
            note_mismatch("ok", got.ok, want.ok);
        if (got.found_slot !== want.found_slot)
            note_mismatch("found_slot", got.found_slot, want.found_slot);
        if (got.entry_address !== want.entry_address)
            note_mismatch("entry_address", got.entry_address, want.entry_address);
        if (got.entry_size !== want.entry_size)
            note_mismatch("entry_size", got.entry_size, want.entry_size);
        if (got.free_address !== want.free_address)
            note_mismatch("free_address", got.free_address, want.free_address);
        if (got.free_bytes !== want.free_bytes)
            note_mismatch("free_bytes", got.free_bytes, want.free_bytes);
        if (got.current_slot !== want.current_slot)
            note_mismatch("current_slot", got.current_slot, want.current_slot);
        if (got.current_address !== want.current_address)
            note_mismatch("current_address", got.current_address, want.current_address);
    endtask

    // Take each result mid-cycle, while done is stable, and check it against
    // the oldest pending outcome.
    always @(negedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
                note_mismatch("result with nothing pending, ok", outcome.ok, 0);
            else
            begin
                compare_outcome(outcome, pending_outcomes.pop_front());
                outcomes_checked++;
            end
        end
    end

    // Drive one command transaction. Idle first at the current sender rate,
    // then hold start until an edge with busy low takes it, then record the
    // outcome. Start stays high on return so back-to-back commands keep it up.
    task automatic issue_command(input cmd_t c, input bit typed, input result_t want);
        bit      taken;
        result_t predicted;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        command <= c;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        predicted = predict_outcome(c);
        pending_outcomes.push_back(typed ? want : predicted);
        kind_count[c.kind]++;
    endtask

    // Hold off new commands until every pending outcome has arrived.
    task automatic drain_pending();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_outcomes.size() != 0);
    endtask

    // Write partition_size only once the block is idle.
    task automatic write_partition_size(input logic [ADDR_W-1:0] bytes);
        bit taken;
        drain_pending();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= bytes;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        cfg_valid  <= 1'b0;
        part_bytes = bytes;
    endtask

    task automatic run_random(input int count);
        repeat (count)
        begin
            // Now and then let the block run dry before the next command.
            if ($urandom_range(0, 99) < 4)
                drain_pending();
            issue_command(random_command(), 1'b0, '0);
        end
    endtask

    // Fill every slot with small ROMs, probe the top two slots, push one register
    // past a full table, then free and retake the top slot.
    task automatic fill_table();
        issue_command(make_command(KIND_CLEAR, '0, '0, '0), 1'b0, '0);
        repeat (LIVE_SLOTS + 1)
            issue_command(make_command(KIND_REGISTER, '0, '0,
                                       ADDR_W'($urandom_range(0, 65536))), 1'b0, '0);
        issue_command(make_command(KIND_LOOKUP, SLOT_W'(LIVE_SLOTS - 1), '0, '0), 1'b0, '0);
        issue_command(make_command(KIND_LOOKUP, SLOT_W'(LIVE_SLOTS - 2), '0, '0), 1'b0, '0);
        issue_command(make_command(KIND_SELECT, '0, SLOT_W'(LIVE_SLOTS - 1), '0), 1'b0, '0);
        issue_command(make_command(KIND_DELETE, '0, SLOT_W'(LIVE_SLOTS - 1), '0), 1'b0, '0);
        issue_command(make_command(KIND_REGISTER, '0, '0, ADDR_W'($urandom)), 1'b0, '0);
        issue_command(make_command(KIND_REGISTER, '0, '0, '0), 1'b0, '0);
        issue_command(make_command(KIND_CLEAR, '0, '0, '0), 1'b0, '0);
    endtask

    initial
    begin
        result_t empty_reset;
        empty_reset = typed_outcome(1'b0, '0, '0, '0, '0, ADDR_W'(1048576), '0, '0);

        // Directed table, run at the reset partition size of 1 MiB.
        // Empty table: every lookup, delete, select and unknown kind fails.
        add_row(make_command(KIND_LOOKUP, '0, '0, '0), 1'b1, empty_reset);
        add_row(make_command(KIND_LOOKUP, '1, '1, '1), 1'b1, empty_reset);
        add_row(make_command(KIND_DELETE, '0, '0, '0), 1'b1, empty_reset);
        add_row(make_command(KIND_SELECT, '0, '1, '0), 1'b1, empty_reset);
        add_row(make_command(KIND_SPARE_FIRST, '0, '0, '0), 1'b1, empty_reset);
        add_row(make_command(KIND_SPARE_LAST, '1, '1, '1), 1'b1, empty_reset);
        // Zero-size ROM takes slot 0 with no length; one byte rounds to a page.
        add_row(make_command(KIND_REGISTER, '0, '0, '0), 1'b1,
                typed_outcome(1'b1, '0, '0, '0, '0, ADDR_W'(1048576), '0, '0));
        add_row(make_command(KIND_REGISTER, '0, '0, ADDR_W'(1)), 1'b1,
                typed_outcome(1'b1, SLOT_W'(1), '0, ADDR_W'(65536), ADDR_W'(65536),
                              ADDR_W'(983040), '0, '0));
        // Largest size overflows the address range.
        add_row(make_command(KIND_REGISTER, '0, '0, '1), 1'b1,
                typed_outcome(1'b0, '0, '0, '0, ADDR_W'(65536), ADDR_W'(983040), '0, '0));
        add_row(make_command(KIND_REGISTER, '0, '0, ADDR_W'(65536)), 1'b0, '0);
        add_row(make_command(KIND_LOOKUP, SLOT_W'(1), '0, '0), 1'b0, '0);
        add_row(make_command(KIND_SELECT, '0, SLOT_W'(2), '0), 1'b0, '0);
        // Delete the current slot: the selection stays, a reselect fails.
        add_row(make_command(KIND_DELETE, '0, SLOT_W'(2), '0), 1'b0, '0);
        add_row(make_command(KIND_SELECT, '0, SLOT_W'(2), '0), 1'b0, '0);
        // End exactly at the start of the top page, then one page more overflows.
        add_row(make_command(KIND_REGISTER, '0, '0, ADDR_W'(25'h1FE0000)), 1'b0, '0);
        add_row(make_command(KIND_REGISTER, '0, '0, ADDR_W'(1)), 1'b0, '0);
        add_row(make_command(KIND_LOOKUP, SLOT_W'(2), '0, '0), 1'b0, '0);
        add_row(make_command(KIND_DELETE, '0, '1, '0), 1'b0, '0);
        add_row(make_command(KIND_SELECT, '0, '0, '0), 1'b0, '0);
        // Clear always succeeds and drops everything, selection included.
        add_row(make_command(KIND_CLEAR, '0, '0, '0), 1'b1,
                typed_outcome(1'b1, '0, '0, '0, '0, ADDR_W'(1048576), '0, '0));
        add_row(make_command(KIND_LOOKUP, '0, '0, '0), 1'b1, empty_reset);

        for (int i = 0; i < LIVE_SLOTS; i++)
            slot_used[i] = 1'b0;
        foreach (kind_count[k])
            kind_count[k] = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase one: sender idles rarely; directed rows, then random at partition 0.
        sender_idle_pct = 10;
        foreach (rows[i])
            issue_command(rows[i].cmd, rows[i].typed, rows[i].want);
        write_partition_size('0);
        run_random(65);

        // Phase two: sender idles most cycles; partition at its largest.
        sender_idle_pct = 85;
        write_partition_size('1);
        run_random(65);

        // Phase three: back-to-back commands, random partition, full table.
        sender_idle_pct = 0;
        write_partition_size(ADDR_W'($urandom));
        fill_table();
        run_random(65);

        drain_pending();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d lookup, %0d register, %0d delete, %0d select, %0d clear, %0d unknown",
                 kind_count[KIND_LOOKUP], kind_count[KIND_REGISTER], kind_count[KIND_DELETE],
                 kind_count[KIND_SELECT], kind_count[KIND_CLEAR],
                 kind_count[5] + kind_count[6] + kind_count[7]);
        $display("checked %0d results field by field over four partition sizes, %0d mismatches",
                 outcomes_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
rtl/core/rsa_pkg.sv
rtl/core/rom_slot_allocator.sv
verif/rom_slot_allocator_tb.sv
